>>> hdl/gmd_pkg.sv
// Shared package of the grid maze depth-first path finder.
// Holds sizes, codes, item structs and the controller/datapath interface.
// No dependencies.
`default_nettype none

package gmd_pkg;

    localparam int MAX_ROWS   = 32;
    localparam int MAX_COLS   = 32;
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int NCELLS     = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W     = ROW_W + COL_W;
    localparam int DEPTH_W    = $clog2(NCELLS + 1);
    localparam int SIZE_W     = 6;
    localparam int MIN_SIZE   = 4;
    localparam int SIZE_RESET = 20;
    localparam int DIR_W      = 3;
    localparam int GUARD_INIT = 4 * NCELLS + 4;
    localparam int GUARD_W    = $clog2(GUARD_INIT + 1);
    localparam int CFG_IDX_W  = 1;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 1'd1;

    typedef enum logic [1:0] {
        FUNC_WRITE = 2'd0,
        FUNC_SOLVE = 2'd1,
        FUNC_READ  = 2'd2
    } func_t;

    localparam logic [DIR_W-1:0] DIR_NONE  = 3'd0;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd1;
    localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd2;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd3;
    localparam logic [DIR_W-1:0] DIR_UP    = 3'd4;

    typedef struct packed {
        logic [1:0]        func;
        logic [ROW_W-1:0]  cell_row;
        logic [COL_W-1:0]  cell_col;
        logic              wall;
        logic [ADDR_W-1:0] step_index;
    } in_item_t;

    typedef struct packed {
        logic               found;
        logic [DEPTH_W-1:0] path_length;
        logic               step_valid;
        logic [ROW_W-1:0]   step_row;
        logic [COL_W-1:0]   step_col;
        logic [DIR_W-1:0]   step_dir;
    } out_item_t;

    typedef struct packed {
        logic             wall;
        logic             visited;
        logic [DIR_W-1:0] dir;
    } cell_entry_t;

    typedef struct packed {
        logic clr_step;
        logic load_write;
        logic load_read;
        logic solve_init;
        logic top_load;
        logic try_fail;
        logic check_eval;
        logic pop_load;
        logic read_fetch;
        logic res_solve;
        logic res_read;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic try_done;
        logic nb_open;
        logic nb_goal;
        logic guard_zero;
        logic depth_one;
    } status_t;

endpackage

`default_nettype wire

>>> hdl/gmd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module gmd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> hdl/gmd_dp.sv
// Datapath of the maze path finder: size registers, cell and stack memories,
// search registers and the result register. Depends on gmd_pkg and gmd_ram.
`default_nettype none

module gmd_dp
    import gmd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire in_item_t             item,
    input  wire logic                 cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [SIZE_W-1:0]    cfg_data,
    input  wire cmd_t                 cmd,
    output status_t                   status,
    output out_item_t                 result
);

    localparam logic [ADDR_W-1:0] START_ADDR = {ROW_W'(1), COL_W'(1)};

    logic [SIZE_W-1:0]  row_count_reg;
    logic [SIZE_W-1:0]  col_count_reg;
    logic [ADDR_W-1:0]  clr_reg;
    logic [DEPTH_W-1:0] depth_reg;
    logic               found_reg;
    logic [GUARD_W-1:0] guard_reg;
    logic [DIR_W-1:0]   try_reg;
    logic [ROW_W-1:0]   cur_r_reg;
    logic [COL_W-1:0]   cur_c_reg;
    logic               cur_wall_reg;
    logic [DIR_W-1:0]   cur_dir_reg;
    logic [ADDR_W-1:0]  si_reg;
    logic [ADDR_W-1:0]  rd_cell_reg;
    out_item_t          result_reg;

    logic [SIZE_W-1:0]  nr;
    logic [SIZE_W-1:0]  nc;
    logic [ROW_W-1:0]   nb_r;
    logic [COL_W-1:0]   nb_c;
    logic [ADDR_W-1:0]  nb_addr;
    logic [ADDR_W-1:0]  cur_addr;
    logic               nb_border;
    logic               nb_goal;
    logic               nb_start;
    logic               nb_open;
    logic [DEPTH_W-1:0] depth_m2;
    logic [DEPTH_W-1:0] plen;
    logic               in_path;
    logic               last_step;

    logic                        cell_we;
    logic [ADDR_W-1:0]           cell_waddr;
    cell_entry_t                 cell_wdata;
    logic [ADDR_W-1:0]           cell_raddr;
    logic [$bits(cell_entry_t)-1:0] cell_rdata;
    cell_entry_t                 cell_rd;
    logic                        stack_we;
    logic [ADDR_W-1:0]           stack_waddr;
    logic [ADDR_W-1:0]           stack_wdata;
    logic [ADDR_W-1:0]           stack_raddr;
    logic [ADDR_W-1:0]           stack_rdata;

    assign cell_rd = cell_entry_t'(cell_rdata);

    always_comb
    begin
        if (row_count_reg < SIZE_W'(MIN_SIZE))
            nr = SIZE_W'(MIN_SIZE);
        else if (row_count_reg > SIZE_W'(MAX_ROWS))
            nr = SIZE_W'(MAX_ROWS);
        else
            nr = row_count_reg;
        if (col_count_reg < SIZE_W'(MIN_SIZE))
            nc = SIZE_W'(MIN_SIZE);
        else if (col_count_reg > SIZE_W'(MAX_COLS))
            nc = SIZE_W'(MAX_COLS);
        else
            nc = col_count_reg;
    end

    always_comb
    begin
        nb_r = cur_r_reg;
        nb_c = cur_c_reg;
        case (try_reg)
            DIR_NONE:  nb_c = cur_c_reg + COL_W'(1);
            DIR_RIGHT: nb_r = cur_r_reg + ROW_W'(1);
            DIR_DOWN:  nb_c = cur_c_reg - COL_W'(1);
            default:   nb_r = cur_r_reg - ROW_W'(1);
        endcase
    end

    assign nb_addr   = {nb_r, nb_c};
    assign cur_addr  = {cur_r_reg, cur_c_reg};
    assign nb_border = (nb_r == '0) || (nb_c == '0) ||
                       (SIZE_W'(nb_r) == nr - SIZE_W'(1)) ||
                       (SIZE_W'(nb_c) == nc - SIZE_W'(1));
    assign nb_goal   = (SIZE_W'(nb_r) == nr - SIZE_W'(2)) &&
                       (SIZE_W'(nb_c) == nc - SIZE_W'(2));
    assign nb_start  = (nb_r == ROW_W'(1)) && (nb_c == COL_W'(1));
    assign nb_open   = !nb_border && (nb_start || nb_goal || !cell_rd.wall) &&
                       !cell_rd.visited;

    assign depth_m2  = depth_reg - DEPTH_W'(2);
    assign plen      = found_reg ? depth_reg : '0;
    assign in_path   = DEPTH_W'(si_reg) < plen;
    assign last_step = (DEPTH_W'(si_reg) + DEPTH_W'(1)) == plen;

    always_comb
    begin
        cell_we    = 1'b0;
        cell_waddr = cur_addr;
        cell_wdata = '0;
        if (cmd.clr_step)
        begin
            cell_we    = 1'b1;
            cell_waddr = clr_reg;
        end
        else if (cmd.load_write)
        begin
            cell_we    = 1'b1;
            cell_waddr = {item.cell_row, item.cell_col};
            cell_wdata = '{wall: item.wall, visited: 1'b0, dir: DIR_NONE};
        end
        else if (cmd.try_fail)
        begin
            cell_we    = 1'b1;
            cell_wdata = '{wall: cur_wall_reg, visited: 1'b1, dir: cur_dir_reg};
        end
        else if (cmd.check_eval && nb_open)
        begin
            cell_we    = 1'b1;
            cell_wdata = '{wall: cur_wall_reg, visited: 1'b1,
                           dir: try_reg + DIR_W'(1)};
        end
    end

    always_comb
    begin
        if (cmd.solve_init)
            cell_raddr = START_ADDR;
        else if (cmd.pop_load || cmd.read_fetch)
            cell_raddr = stack_rdata;
        else
            cell_raddr = nb_addr;
    end

    assign stack_we    = cmd.solve_init || (cmd.check_eval && nb_open);
    assign stack_waddr = cmd.solve_init ? '0 : depth_reg[ADDR_W-1:0];
    assign stack_wdata = cmd.solve_init ? START_ADDR : nb_addr;
    assign stack_raddr = cmd.load_read ? item.step_index : depth_m2[ADDR_W-1:0];

    gmd_ram #(
        .WIDTH ($bits(cell_entry_t)),
        .DEPTH (NCELLS)
    ) u_cell_ram (
        .clk   (clk),
        .we    (cell_we),
        .waddr (cell_waddr),
        .wdata (cell_wdata),
        .raddr (cell_raddr),
        .rdata (cell_rdata)
    );

    gmd_ram #(
        .WIDTH (ADDR_W),
        .DEPTH (NCELLS)
    ) u_stack_ram (
        .clk   (clk),
        .we    (stack_we),
        .waddr (stack_waddr),
        .wdata (stack_wdata),
        .raddr (stack_raddr),
        .rdata (stack_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= SIZE_W'(SIZE_RESET);
            col_count_reg <= SIZE_W'(SIZE_RESET);
            clr_reg       <= '0;
            depth_reg     <= '0;
            found_reg     <= 1'b0;
            guard_reg     <= '0;
            try_reg       <= DIR_NONE;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_ROW_COUNT: row_count_reg <= cfg_data;
                    REG_COL_COUNT: col_count_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.clr_step)
                clr_reg <= clr_reg + ADDR_W'(1);
            if (cmd.solve_init)
            begin
                found_reg <= 1'b0;
                depth_reg <= DEPTH_W'(1);
                guard_reg <= GUARD_W'(GUARD_INIT);
            end
            if (cmd.top_load)
            begin
                try_reg   <= cell_rd.dir;
                guard_reg <= guard_reg - GUARD_W'(1);
            end
            if (cmd.try_fail)
            begin
                if (status.depth_one || status.guard_zero)
                    depth_reg <= '0;
                else
                    depth_reg <= depth_reg - DEPTH_W'(1);
            end
            if (cmd.check_eval)
            begin
                if (nb_open)
                begin
                    if (nb_goal)
                    begin
                        found_reg <= 1'b1;
                        depth_reg <= depth_reg + DEPTH_W'(1);
                    end
                    else if (status.guard_zero)
                    begin
                        depth_reg <= '0;
                    end
                    else
                    begin
                        depth_reg <= depth_reg + DEPTH_W'(1);
                        try_reg   <= cell_rd.dir;
                        guard_reg <= guard_reg - GUARD_W'(1);
                    end
                end
                else
                begin
                    try_reg <= try_reg + DIR_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_read)
            si_reg <= item.step_index;
        if (cmd.solve_init)
        begin
            cur_r_reg <= ROW_W'(1);
            cur_c_reg <= COL_W'(1);
        end
        if (cmd.top_load)
        begin
            cur_wall_reg <= cell_rd.wall;
            cur_dir_reg  <= cell_rd.dir;
        end
        if (cmd.check_eval && nb_open)
        begin
            cur_r_reg    <= nb_r;
            cur_c_reg    <= nb_c;
            cur_wall_reg <= cell_rd.wall;
            cur_dir_reg  <= cell_rd.dir;
        end
        if (cmd.pop_load)
        begin
            cur_r_reg <= stack_rdata[ADDR_W-1:COL_W];
            cur_c_reg <= stack_rdata[COL_W-1:0];
        end
        if (cmd.read_fetch)
            rd_cell_reg <= stack_rdata;
        if (cmd.res_solve)
        begin
            result_reg             <= '0;
            result_reg.found       <= found_reg;
            result_reg.path_length <= plen;
        end
        if (cmd.res_read)
        begin
            result_reg.found       <= found_reg;
            result_reg.path_length <= plen;
            result_reg.step_valid  <= in_path;
            result_reg.step_row    <= in_path ? rd_cell_reg[ADDR_W-1:COL_W] : '0;
            result_reg.step_col    <= in_path ? rd_cell_reg[COL_W-1:0] : '0;
            result_reg.step_dir    <= (in_path && !last_step) ? cell_rd.dir : DIR_NONE;
        end
    end

    assign status.clr_last   = &clr_reg;
    assign status.try_done   = try_reg >= DIR_UP;
    assign status.nb_open    = nb_open;
    assign status.nb_goal    = nb_goal;
    assign status.guard_zero = guard_reg == '0;
    assign status.depth_one  = depth_reg == DEPTH_W'(1);
    assign result            = result_reg;

    // The stack never holds more entries than the grid has cells.
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DEPTH_W'(NCELLS))
        else $error("stack depth exceeds the cell count");

    // The tried-move count stays within the four moves.
    a_try_bound: assert property (@(posedge clk) disable iff (!rst_n)
        try_reg <= DIR_UP)
        else $error("move counter out of range");

endmodule

`default_nettype wire

>>> hdl/gmd_ctrl.sv
// Controller of the maze path finder: sequences the memory clear, cell
// writes, the depth-first search and path reads. Depends on gmd_pkg.
`default_nettype none

module gmd_ctrl
    import gmd_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    input  wire logic [1:0] func,
    input  wire status_t status,
    output cmd_t         cmd,
    output logic         busy,
    output logic         done
);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOADTOP,
        ST_TRY,
        ST_CHECK,
        ST_POP,
        ST_FIN,
        ST_RDFETCH,
        ST_RDOUT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   done_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (status.clr_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (start && !busy_reg)
                begin
                    case (func)
                        FUNC_WRITE:
                        begin
                            cmd.load_write = 1'b1;
                        end
                        FUNC_SOLVE:
                        begin
                            cmd.solve_init = 1'b1;
                            state_next     = ST_LOADTOP;
                        end
                        FUNC_READ:
                        begin
                            cmd.load_read = 1'b1;
                            state_next    = ST_RDFETCH;
                        end
                        default: ;
                    endcase
                end
            end
            ST_LOADTOP:
            begin
                cmd.top_load = 1'b1;
                state_next   = ST_TRY;
            end
            ST_TRY:
            begin
                if (status.try_done)
                begin
                    cmd.try_fail = 1'b1;
                    if (status.depth_one || status.guard_zero)
                        state_next = ST_FIN;
                    else
                        state_next = ST_POP;
                end
                else
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                cmd.check_eval = 1'b1;
                if (status.nb_open && (status.nb_goal || status.guard_zero))
                    state_next = ST_FIN;
                else
                    state_next = ST_TRY;
            end
            ST_POP:
            begin
                cmd.pop_load = 1'b1;
                state_next   = ST_LOADTOP;
            end
            ST_FIN:
            begin
                cmd.res_solve = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_RDFETCH:
            begin
                cmd.read_fetch = 1'b1;
                state_next     = ST_RDOUT;
            end
            ST_RDOUT:
            begin
                cmd.res_read = 1'b1;
                state_next   = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            busy_reg  <= 1'b1;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= state_next != ST_IDLE;
            done_reg  <= cmd.res_solve || cmd.res_read;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

    // A result beat never repeats in the following cycle.
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held for two cycles");

    // A cell write completes in the cycle it is accepted.
    a_write_no_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && start && !busy_reg && func == FUNC_WRITE)
        |=> !busy_reg)
        else $error("cell write left the block busy");

    // Backtracking out of the start cell ends the search with a result.
    a_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TRY && status.try_done && status.depth_one)
        |=> ##1 done_reg)
        else $error("empty stack did not finish the search");

endmodule

`default_nettype wire

>>> hdl/grid_maze_dfs_path_finder.sv
// Maze path finder by depth-first search: the cell memory holds a wall bit, a visited mark
// and the last move tried for each cell, and a stack memory holds the path. After reset the
// block clears all 1024 cell memory entries with busy high. A cell write (func 0) leaves busy
// low. A path read (func 2) makes two dependent reads, first of the stack and then of the
// cell memory, before its result beat. A solve (func 1) runs one search step per memory read:
// entering a cell after a backtrack passes through ST_POP and ST_LOADTOP, and each move tried
// passes through ST_TRY and ST_CHECK. Each result beat is shown on result for exactly one
// cycle with done high, and must be taken then. The user must write the size registers only
// while the block is idle; the block itself does not enforce it.
`default_nettype none

module grid_maze_dfs_path_finder
    import gmd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire in_item_t             item,
    output logic                      busy,
    output logic                      done,
    output out_item_t                 result,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [SIZE_W-1:0]    cfg_data
);

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    gmd_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .func   (item.func),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    gmd_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .result    (result)
    );

endmodule

`default_nettype wire

>>> tb/grid_maze_dfs_path_finder_tb.sv
// Testbench for grid_maze_dfs_path_finder: loads mazes of many sizes, solves them and reads
// the paths back, checking each result beat against a built-in depth-first search predictor.
// Depends on gmd_pkg and on the grid_maze_dfs_path_finder module.
module grid_maze_dfs_path_finder_tb;
    import gmd_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int QUIET_LIMIT = 200000;
    localparam int RANDOM_OPS  = 140;

    class maze_scoreboard;
        bit                wall_q[NCELLS];
        bit                seen_q[NCELLS];
        bit [DIR_W-1:0]    move_q[NCELLS];
        bit [ADDR_W-1:0]   trail[NCELLS];
        int                trail_len;
        bit                reached;
        int                rows_cfg;
        int                cols_cfg;
        out_item_t         answers_due[$];
        int                mismatches;
        int                checked;
        int                solves;
        int                goal_hits;
        int                reads;
        int                reads_on_path;
        int                writes;

        function new();
            rows_cfg = SIZE_RESET;
            cols_cfg = SIZE_RESET;
        endfunction

        function void set_size(logic [CFG_IDX_W-1:0] idx, int val);
            if (idx == REG_ROW_COUNT)
                rows_cfg = val & ((1 << SIZE_W) - 1);
            else
                cols_cfg = val & ((1 << SIZE_W) - 1);
        endfunction

        function int fit(int v, int hi);
            if (v < MIN_SIZE)
                return MIN_SIZE;
            if (v > hi)
                return hi;
            return v;
        endfunction

        function int live_rows();
            return fit(rows_cfg, MAX_ROWS);
        endfunction

        function int live_cols();
            return fit(cols_cfg, MAX_COLS);
        endfunction

        function int path_len();
            return reached ? trail_len : 0;
        endfunction

        function int outstanding();
            return answers_due.size();
        endfunction

        function bit blocked(int r, int c, int nr, int nc);
            if (r == 0 || c == 0 || r == nr - 1 || c == nc - 1)
                return 1'b1;
            if ((r == 1 && c == 1) || (r == nr - 2 && c == nc - 2))
                return 1'b0;
            return wall_q[r * MAX_COLS + c];
        endfunction

        // Depth-first search: moves right, down, left, up in that order; the stored move of a
        // cell says which ones were already tried, so a later search resumes from there.
        function void run_search();
            int nr;
            int nc;
            int guard;
            int top;
            int r;
            int c;
            int nbr_r;
            int nbr_c;
            int m;
            bit moved;
            nr = live_rows();
            nc = live_cols();
            guard = 4 * NCELLS + 4;
            reached = 1'b0;
            trail_len = 1;
            trail[0] = 1 * MAX_COLS + 1;
            while (trail_len > 0 && guard > 0)
            begin
                top = trail[trail_len - 1];
                r = top / MAX_COLS;
                c = top % MAX_COLS;
                guard--;
                seen_q[top] = 1'b1;
                moved = 1'b0;
                nbr_r = r;
                nbr_c = c;
                for (m = move_q[top] + 1; m <= DIR_UP && !moved; m++)
                begin
                    nbr_r = r;
                    nbr_c = c;
                    case (m)
                        DIR_RIGHT: nbr_c = c + 1;
                        DIR_DOWN:  nbr_r = r + 1;
                        DIR_LEFT:  nbr_c = c - 1;
                        default:   nbr_r = r - 1;
                    endcase
                    if (!blocked(nbr_r, nbr_c, nr, nc) && !seen_q[nbr_r * MAX_COLS + nbr_c])
                    begin
                        move_q[top] = m;
                        moved = 1'b1;
                    end
                end
                if (!moved)
                    trail_len--;
                else
                begin
                    if (trail_len < NCELLS)
                    begin
                        trail[trail_len] = nbr_r * MAX_COLS + nbr_c;
                        trail_len++;
                    end
                    if (nbr_r == nr - 2 && nbr_c == nc - 2)
                    begin
                        reached = 1'b1;
                        return;
                    end
                end
            end
            trail_len = 0;
        endfunction

        function void note_item(in_item_t it);
            out_item_t want;
            int plen;
            int si;
            logic [ADDR_W-1:0] spot;
            case (it.func)
                FUNC_WRITE:
                begin
                    spot = {it.cell_row, it.cell_col};
                    wall_q[spot] = it.wall;
                    seen_q[spot] = 1'b0;
                    move_q[spot] = DIR_NONE;
                    writes++;
                    return;
                end
                FUNC_SOLVE:
                begin
                    run_search();
                    solves++;
                    goal_hits += reached;
                end
                FUNC_READ:
                    reads++;
                default:
                    return;
            endcase
            plen = path_len();
            want = '0;
            want.found = reached;
            want.path_length = plen[DEPTH_W-1:0];
            si = it.step_index;
            if (it.func == FUNC_READ && si < plen)
            begin
                spot = trail[si];
                want.step_valid = 1'b1;
                want.step_row = spot[ADDR_W-1:COL_W];
                want.step_col = spot[COL_W-1:0];
                want.step_dir = (si + 1 == plen) ? DIR_NONE : move_q[spot];
                reads_on_path++;
            end
            answers_due.push_back(want);
        endfunction

        function string describe(out_item_t v);
            return $sformatf("found=%0d len=%0d valid=%0d row=%0d col=%0d dir=%0d",
                             v.found, v.path_length, v.step_valid, v.step_row, v.step_col,
                             v.step_dir);
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            checked++;
            if (answers_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Result beat with nothing expected: %s", describe(got));
                return;
            end
            want = answers_due.pop_front();
            if (got.found !== want.found || got.path_length !== want.path_length ||
                got.step_valid !== want.step_valid || got.step_row !== want.step_row ||
                got.step_col !== want.step_col || got.step_dir !== want.step_dir)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Mismatch on beat %0d: expected %s, got %s", checked,
                             describe(want), describe(got));
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    in_item_t             item = '0;
    logic                 busy;
    logic                 done;
    out_item_t            result;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [SIZE_W-1:0]    cfg_data = '0;

    maze_scoreboard board;
    bit             written[NCELLS];
    bit             gaps_on = 1'b1;
    int             size_settings = 0;
    int             quiet = 0;

    grid_maze_dfs_path_finder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item      (item),
        .busy      (busy),
        .done      (done),
        .result    (result),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            board.check_result(result);
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("grid_maze_dfs_path_finder verification failed");
            $finish;
        end
    end

    task automatic send_item(input in_item_t it);
        if (gaps_on && $urandom_range(0, 99) < 13)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        start <= 1'b1;
        item <= it;
        do
            @(posedge clk);
        while (busy);
        board.note_item(it);
    endtask

    task automatic send_write(input int r, input int c, input bit w);
        in_item_t it;
        it = '0;
        it.func = FUNC_WRITE;
        it.cell_row = r[ROW_W-1:0];
        it.cell_col = c[COL_W-1:0];
        it.wall = w;
        it.step_index = $urandom;
        send_item(it);
        written[r * MAX_COLS + c] = 1'b1;
    endtask

    task automatic send_op(input logic [1:0] op, input int step);
        in_item_t it;
        it.func = op;
        it.cell_row = $urandom;
        it.cell_col = $urandom;
        it.wall = $urandom;
        it.step_index = step[ADDR_W-1:0];
        send_item(it);
    endtask

    task automatic settle();
        start <= 1'b0;
        do
            @(posedge clk);
        while (board.outstanding() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_maze_size(input int rows, input int cols);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= REG_ROW_COUNT;
        cfg_data <= rows[SIZE_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        board.set_size(REG_ROW_COUNT, rows);
        cfg_index <= REG_COL_COUNT;
        cfg_data <= cols[SIZE_W-1:0];
        do
            @(posedge clk);
        while (!cfg_ready);
        board.set_size(REG_COL_COUNT, cols);
        cfg_valid <= 1'b0;
        size_settings++;
    endtask

    task automatic load_maze(input int nr, input int nc, input int wall_pct);
        for (int r = 1; r <= nr - 2; r++)
            for (int c = 1; c <= nc - 2; c++)
                send_write(r, c, $urandom_range(0, 99) < wall_pct);
    endtask

    function automatic bit covered(int nr, int nc);
        for (int r = 1; r <= nr - 2; r++)
            for (int c = 1; c <= nc - 2; c++)
                if (!written[r * MAX_COLS + c])
                    return 1'b0;
        return 1'b1;
    endfunction

    function automatic int pick_size();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, MIN_SIZE - 1);
            1:       return MIN_SIZE;
            2:       return MAX_ROWS;
            3:       return $urandom_range(MAX_ROWS + 1, (1 << SIZE_W) - 1);
            4:       return $urandom_range(11, 20);
            default: return $urandom_range(MIN_SIZE, 10);
        endcase
    endfunction

    function automatic int pick_step();
        int plen;
        plen = board.path_len();
        if (plen > 0 && $urandom_range(0, 9) < 6)
            return $urandom_range(0, plen - 1);
        case ($urandom_range(0, 3))
            0:       return plen;
            1:       return (plen > 0) ? plen - 1 : 0;
            2:       return NCELLS - 1;
            default: return $urandom_range(0, NCELLS - 1);
        endcase
    endfunction

    initial
    begin
        int rows_plan[4] = '{32, 4, 0, 63};
        int cols_plan[4] = '{32, 63, 3, 4};
        int phase;
        int ops;
        int nr;
        int nc;
        board = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        send_op(FUNC_READ, 0);
        send_op(FUNC_READ, NCELLS - 1);
        send_op(FUNC_UNUSED, NCELLS - 1);
        set_maze_size(MIN_SIZE, MIN_SIZE);
        send_write(1, 1, 1'b1);
        send_write(1, 2, 1'b1);
        send_write(2, 1, 1'b1);
        send_write(2, 2, 1'b1);
        send_op(FUNC_SOLVE, 0);
        send_op(FUNC_READ, 0);
        send_write(1, 2, 1'b0);
        send_op(FUNC_SOLVE, 0);
        for (int i = 0; i < 4; i++)
            send_op(FUNC_READ, i);
        send_op(FUNC_SOLVE, 0);
        send_op(FUNC_READ, 0);
        send_write(31, 31, 1'b1);
        send_write(0, 0, 1'b0);

        phase = 0;
        ops = 0;
        while (ops < RANDOM_OPS)
        begin
            gaps_on = !(phase >= 5 && phase < 11);
            if (phase < 4)
                set_maze_size(rows_plan[phase], cols_plan[phase]);
            else if ($urandom_range(0, 2) == 0)
                set_maze_size(pick_size(), pick_size());
            else if ($urandom_range(0, 4) == 0)
                settle();
            nr = board.live_rows();
            nc = board.live_cols();
            // Reads here come before this pass writes any cells and see the path of the last solve.
            if ($urandom_range(0, 3) == 0)
            begin
                send_op(FUNC_READ, pick_step());
                ops++;
            end
            if (!covered(nr, nc) || $urandom_range(0, 4) != 0)
                load_maze(nr, nc, $urandom_range(5, 45));
            if ($urandom_range(0, 3) == 0)
                send_write($urandom_range(0, 31), $urandom_range(0, 31), $urandom_range(0, 1));
            if ($urandom_range(0, 4) == 0)
                send_op(FUNC_UNUSED, $urandom_range(0, NCELLS - 1));
            repeat ($urandom_range(1, 2))
            begin
                send_op(FUNC_SOLVE, $urandom_range(0, NCELLS - 1));
                ops++;
                repeat ($urandom_range(1, 6))
                begin
                    send_op(FUNC_READ, pick_step());
                    ops++;
                end
            end
            phase++;
        end

        settle();
        repeat (20) @(posedge clk);
        $display("Ran %0d solves (%0d reached the goal) and %0d path reads (%0d inside a path)",
                 board.solves, board.goal_hits, board.reads, board.reads_on_path);
        $display("after %0d cell writes under %0d size settings; %0d beats checked, %0d bad.",
                 board.writes, size_settings, board.checked, board.mismatches);
        if (board.mismatches == 0 && board.outstanding() == 0)
            $display("grid_maze_dfs_path_finder verification clean");
        else
            $display("grid_maze_dfs_path_finder verification failed");
        $finish;
    end

endmodule
